### src/ddmd_pkg.sv
package ddmd_pkg;

  localparam int unsigned MATRIX_SIDE_DEF = 5;
  localparam int unsigned DIGIT_COUNT_DEF = 10;

  localparam int unsigned FONT_SIDE   = 5;
  localparam int unsigned FONT_DIGITS = 10;
  localparam int unsigned DIGIT_W     = 4;
  localparam int unsigned POS_W       = 3;   // row/column width at the largest side
  localparam int unsigned PIX_INDEX_W = 5;
  localparam int unsigned PIX_WORD_W  = 32;
  localparam int unsigned TIME_W      = 64;
  localparam int unsigned DEBOUNCE_W  = 20;
  localparam int unsigned LEVEL_W     = 8;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 20;

  localparam logic [DIGIT_W-1:0]    BLANK_CODE       = 4'd15;
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST     = 20'd100000;
  localparam logic [LEVEL_W-1:0]    RED_RST          = 8'd255;
  localparam logic [LEVEL_W-1:0]    GREEN_RST        = 8'd0;
  localparam logic [LEVEL_W-1:0]    BLUE_RST         = 8'd0;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_RED      = 2'd1,
    REG_GREEN    = 2'd2,
    REG_BLUE     = 2'd3
  } cfg_reg_e;

  // column 0 in bit 4
  localparam logic [FONT_SIDE-1:0] FONT_ROWS [FONT_DIGITS][FONT_SIDE] = '{
    '{5'h1F, 5'h11, 5'h11, 5'h11, 5'h1F},
    '{5'h1F, 5'h04, 5'h04, 5'h0C, 5'h04},
    '{5'h1F, 5'h10, 5'h1F, 5'h01, 5'h1F},
    '{5'h1F, 5'h01, 5'h1F, 5'h01, 5'h1F},
    '{5'h10, 5'h01, 5'h1F, 5'h11, 5'h11},
    '{5'h1F, 5'h01, 5'h1F, 5'h10, 5'h1F},
    '{5'h1F, 5'h11, 5'h1F, 5'h10, 5'h1F},
    '{5'h10, 5'h01, 5'h10, 5'h01, 5'h1F},
    '{5'h1F, 5'h11, 5'h1F, 5'h11, 5'h1F},
    '{5'h1F, 5'h01, 5'h1F, 5'h11, 5'h1F}
  };

  function automatic logic font_lit(logic [DIGIT_W-1:0] digit, logic [POS_W-1:0] row,
                                    logic [POS_W-1:0] col);
    logic [FONT_SIDE-1:0] bits;
    logic [POS_W-1:0]     sel;
    font_lit = 1'b0;
    if (digit < DIGIT_W'(FONT_DIGITS) && row < POS_W'(FONT_SIDE) &&
        col < POS_W'(FONT_SIDE)) begin
      bits     = FONT_ROWS[digit][row];
      sel      = POS_W'(FONT_SIDE - 1) - col;
      font_lit = bits[sel];
    end
  endfunction

endpackage

### src/ddmd_if.sv
interface ddmd_req_if;
  logic                            valid;
  logic                            ready;
  logic                            button_select;
  logic                            button_level;
  logic [ddmd_pkg::TIME_W-1:0]     time_us;

  modport source (output valid, button_select, button_level, time_us, input ready);
  modport sink   (input valid, button_select, button_level, time_us, output ready);
endinterface

interface ddmd_pix_if;
  logic                               valid;
  logic                               ready;
  logic [ddmd_pkg::PIX_WORD_W-1:0]    pixel_word;
  logic [ddmd_pkg::PIX_INDEX_W-1:0]   pixel_index;
  logic                               last_pixel;

  modport source (output valid, pixel_word, pixel_index, last_pixel, input ready);
  modport sink   (input valid, pixel_word, pixel_index, last_pixel, output ready);
endinterface

interface ddmd_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [ddmd_pkg::CFG_INDEX_W-1:0]   index;
  logic [ddmd_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### src/debounced_digit_matrix_display.sv
// Debounced digit display for a square LED matrix.
// req_i: button requests (select, pin level, microsecond timestamp). A request
//   with level low whose button was last accepted at least debounce_interval_us
//   earlier (modulo 2^64) steps the digit up (select 0) or down (select 1).
//   Other requests are dropped with no result and no state change.
// pix_o: each accepted press emits one frame of MatrixSide*MatrixSide pixel
//   words in row-major order, last_pixel set on the final one.
// cfg_i: register writes (0 debounce, 1 red, 2 green, 3 blue), always ready;
//   write only while no frame is pending.
// A press starts the generator, which loads pixels into the output register.
// Throughput: req_i.ready drops while a frame is being generated and rises
//   again once its last pixel is loaded; otherwise dropped requests are taken
//   every cycle. A press occupies the generator for MatrixSide*MatrixSide
//   pixels (25 by default), one pixel per cycle unless pix_o.ready stalls it.
// Stalls: while pix_o.ready is low the output register holds its pixel and
//   the generator waits.
// Reset: last press times go to 0, the digit to blank, registers to their
//   defaults (100000 us, red 255, green 0, blue 0); no frame is pending.
module debounced_digit_matrix_display #(
  parameter int unsigned MatrixSide = ddmd_pkg::MATRIX_SIDE_DEF,
  parameter int unsigned DigitCount = ddmd_pkg::DIGIT_COUNT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ddmd_req_if.sink    req_i,
  ddmd_pix_if.source  pix_o,
  ddmd_cfg_if.sink    cfg_i
);

  localparam int unsigned PosW  = (MatrixSide > 1) ? $clog2(MatrixSide) : 1;
  localparam int unsigned IdxW  = $clog2(MatrixSide * MatrixSide);
  localparam int unsigned DW    = ddmd_pkg::DIGIT_W;
  localparam int unsigned TW    = ddmd_pkg::TIME_W;
  localparam int unsigned LW    = ddmd_pkg::LEVEL_W;
  localparam logic [PosW-1:0] PosLast = PosW'(MatrixSide - 1);
  localparam logic [DW-1:0]   DigMax  = DW'(DigitCount - 1);
  localparam logic [DW-1:0]   DigDown = DW'(DigitCount - 2);

  logic [TW-1:0]                    last_up_q, last_up_d;
  logic [TW-1:0]                    last_dn_q, last_dn_d;
  logic [DW-1:0]                    digit_q, digit_d;
  logic [ddmd_pkg::DEBOUNCE_W-1:0]  debounce_q;
  logic [LW-1:0]                    red_q, green_q, blue_q;
  logic                             gen_q, gen_d;
  logic [PosW-1:0]                  row_q, row_d, col_q, col_d;
  logic                             out_valid_q, out_valid_d;
  logic [ddmd_pkg::PIX_WORD_W-1:0]  word_q, word_d;
  logic [ddmd_pkg::PIX_INDEX_W-1:0] index_q, index_d;
  logic                             last_q, last_d;

  logic            req_acc, press, blank, load, pos_last;
  logic [TW-1:0]   last_sel, elapsed;
  logic [IdxW-1:0] idx_full;
  logic            lit;

  assign req_i.ready = !gen_q;
  assign cfg_i.ready = 1'b1;
  assign req_acc     = req_i.valid && req_i.ready;

  assign last_sel = req_i.button_select ? last_dn_q : last_up_q;
  assign elapsed  = req_i.time_us - last_sel;
  assign press    = req_acc && !req_i.button_level &&
                    (elapsed >= TW'(debounce_q));
  assign blank    = digit_q > DigMax;

  assign load     = gen_q && (!out_valid_q || pix_o.ready);
  assign pos_last = (row_q == PosLast) && (col_q == PosLast);
  assign idx_full = IdxW'(row_q) * IdxW'(MatrixSide) + IdxW'(col_q);
  assign lit      = ddmd_pkg::font_lit(digit_q, ddmd_pkg::POS_W'(row_q),
                                       ddmd_pkg::POS_W'(col_q));

  always_comb begin
    last_up_d   = last_up_q;
    last_dn_d   = last_dn_q;
    digit_d     = digit_q;
    gen_d       = gen_q;
    row_d       = row_q;
    col_d       = col_q;
    out_valid_d = out_valid_q;
    word_d      = word_q;
    index_d     = index_q;
    last_d      = last_q;

    if (press) begin
      gen_d = 1'b1;
      row_d = '0;
      col_d = '0;
      if (!req_i.button_select) begin
        last_up_d = req_i.time_us;
        digit_d   = (blank || digit_q == DigMax) ? '0 : digit_q + DW'(1);
      end else begin
        last_dn_d = req_i.time_us;
        digit_d   = blank ? DigDown : ((digit_q == '0) ? DigMax : digit_q - DW'(1));
      end
    end

    if (pix_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
      word_d      = {green_q, (lit ? red_q : LW'(0)), blue_q, LW'(0)};
      index_d     = idx_full[ddmd_pkg::PIX_INDEX_W-1:0];
      last_d      = pos_last;
      if (pos_last) begin
        gen_d = 1'b0;
      end else if (col_q == PosLast) begin
        col_d = '0;
        row_d = row_q + PosW'(1);
      end else begin
        col_d = col_q + PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_up_q   <= '0;
      last_dn_q   <= '0;
      digit_q     <= ddmd_pkg::BLANK_CODE;
      gen_q       <= 1'b0;
      row_q       <= '0;
      col_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      last_up_q   <= last_up_d;
      last_dn_q   <= last_dn_d;
      digit_q     <= digit_d;
      gen_q       <= gen_d;
      row_q       <= row_d;
      col_q       <= col_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q  <= word_d;
    index_q <= index_d;
    last_q  <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= ddmd_pkg::DEBOUNCE_RST;
      red_q      <= ddmd_pkg::RED_RST;
      green_q    <= ddmd_pkg::GREEN_RST;
      blue_q     <= ddmd_pkg::BLUE_RST;
    end else if (cfg_i.valid) begin
      case (ddmd_pkg::cfg_reg_e'(cfg_i.index))
        ddmd_pkg::REG_DEBOUNCE: debounce_q <= cfg_i.data;
        ddmd_pkg::REG_RED:      red_q      <= cfg_i.data[LW-1:0];
        ddmd_pkg::REG_GREEN:    green_q    <= cfg_i.data[LW-1:0];
        ddmd_pkg::REG_BLUE:     blue_q     <= cfg_i.data[LW-1:0];
        default: ;
      endcase
    end
  end

  assign pix_o.valid       = out_valid_q;
  assign pix_o.pixel_word  = word_q;
  assign pix_o.pixel_index = index_q;
  assign pix_o.last_pixel  = last_q;

  a_press_starts_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    press |=> gen_q && row_q == '0 && col_q == '0)
    else $error("press did not start a frame");

  a_drop_keeps_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_acc && !press) |=> $stable(digit_q) && $stable(last_up_q) && $stable(last_dn_q))
    else $error("dropped request changed state");

  a_digit_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (digit_q <= DigMax) || (digit_q == ddmd_pkg::BLANK_CODE))
    else $error("digit out of range");

  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && last_q) |->
      index_q == ddmd_pkg::PIX_INDEX_W'(MatrixSide * MatrixSide - 1))
    else $error("last pixel at wrong index");

endmodule

### bench/tb_debounced_digit_matrix_display.sv
module tb_debounced_digit_matrix_display;
  timeunit 1ns;
  timeprecision 1ps;

  import ddmd_pkg::*;

  localparam int unsigned SIDE               = 5;
  localparam int unsigned DIGITS             = 10;
  localparam int unsigned FRAME_PIXELS       = SIDE * SIDE;
  localparam int unsigned WATCHDOG_LIMIT     = 2000;
  localparam int unsigned IDLE_TAIL          = 8;
  localparam int unsigned PHASES             = 8;
  localparam int unsigned REQUESTS_PER_PHASE = 56;

  localparam logic BTN_UP       = 1'b0;
  localparam logic BTN_DOWN     = 1'b1;
  localparam logic PIN_PRESSED  = 1'b0;
  localparam logic PIN_RELEASED = 1'b1;

  typedef enum logic {ROW_PRESS, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e              kind;
    logic                   sel;
    logic                   lvl;
    logic [TIME_W-1:0]      t;
    cfg_reg_e               reg_idx;
    logic [CFG_DATA_W-1:0]  data;
    logic                   frame;
    logic [DIGIT_W-1:0]     digit;
  } step_row_t;

  typedef struct packed {
    logic [PIX_WORD_W-1:0]  word;
    logic [PIX_INDEX_W-1:0] index;
    logic                   last;
  } pixel_t;

  // column 0 in bit 4
  localparam logic [4:0] GLYPH [10][5] = '{
    '{5'h1F, 5'h11, 5'h11, 5'h11, 5'h1F},
    '{5'h1F, 5'h04, 5'h04, 5'h0C, 5'h04},
    '{5'h1F, 5'h10, 5'h1F, 5'h01, 5'h1F},
    '{5'h1F, 5'h01, 5'h1F, 5'h01, 5'h1F},
    '{5'h10, 5'h01, 5'h1F, 5'h11, 5'h11},
    '{5'h1F, 5'h01, 5'h1F, 5'h10, 5'h1F},
    '{5'h1F, 5'h11, 5'h1F, 5'h10, 5'h1F},
    '{5'h10, 5'h01, 5'h10, 5'h01, 5'h1F},
    '{5'h1F, 5'h11, 5'h1F, 5'h11, 5'h1F},
    '{5'h1F, 5'h01, 5'h1F, 5'h11, 5'h1F}
  };

  localparam step_row_t DIRECTED [25] = '{
    '{ROW_PRESS, BTN_UP,   PIN_PRESSED,  64'd0,       REG_DEBOUNCE, 20'd0, 1'b0, 4'd0},
    '{ROW_PRESS, BTN_DOWN, PIN_PRESSED,  64'd99999,   REG_DEBOUNCE, 20'd0, 1'b0, 4'd0},
    '{ROW_PRESS, BTN_DOWN, PIN_RELEASED, 64'd100000,  REG_DEBOUNCE, 20'd0, 1'b0, 4'd0},
    '{ROW_PRESS, BTN_DOWN, PIN_PRESSED,  64'd100000,  REG_DEBOUNCE, 20'd0, 1'b1, 4'd8},
    '{ROW_PRESS, BTN_DOWN, PIN_PRESSED,  64'd199999,  REG_DEBOUNCE, 20'd0, 1'b0, 4'd0},
    '{ROW_PRESS, BTN_UP,   PIN_PRESSED,  64'd100000,  REG_DEBOUNCE, 20'd0, 1'b1, 4'd9},
    '{ROW_PRESS, BTN_UP,   PIN_PRESSED,  64'd200000,  REG_DEBOUNCE, 20'd0, 1'b1, 4'd0},
    '{ROW_PRESS, BTN_DOWN, PIN_PRESSED,  64'd200000,  REG_DEBOUNCE, 20'd0, 1'b1, 4'd9},
    '{ROW_WRITE, BTN_UP,   PIN_PRESSED,  64'd0,       REG_GREEN, 20'hFF,   1'b0, 4'd0},
    '{ROW_WRITE, BTN_UP,   PIN_PRESSED,  64'd0,       REG_BLUE,  20'hFF,   1'b0, 4'd0},
    '{ROW_PRESS, BTN_UP,   PIN_PRESSED,  64'd300000,  REG_DEBOUNCE, 20'd0, 1'b1, 4'd0},
    '{ROW_PRESS, BTN_UP,   PIN_PRESSED,  64'd400000,  REG_DEBOUNCE, 20'd0, 1'b1, 4'd1},
    '{ROW_PRESS, BTN_UP,   PIN_PRESSED,  64'd500000,  REG_DEBOUNCE, 20'd0, 1'b1, 4'd2},
    '{ROW_PRESS, BTN_UP,   PIN_PRESSED,  64'd600000,  REG_DEBOUNCE, 20'd0, 1'b1, 4'd3},
    '{ROW_PRESS, BTN_UP,   PIN_PRESSED,  64'd700000,  REG_DEBOUNCE, 20'd0, 1'b1, 4'd4},
    '{ROW_PRESS, BTN_UP,   PIN_PRESSED,  64'd800000,  REG_DEBOUNCE, 20'd0, 1'b1, 4'd5},
    '{ROW_PRESS, BTN_UP,   PIN_PRESSED,  64'd900000,  REG_DEBOUNCE, 20'd0, 1'b1, 4'd6},
    '{ROW_PRESS, BTN_UP,   PIN_PRESSED,  64'd1000000, REG_DEBOUNCE, 20'd0, 1'b1, 4'd7},
    '{ROW_PRESS, BTN_UP,   PIN_PRESSED,  64'd1100000, REG_DEBOUNCE, 20'd0, 1'b1, 4'd8},
    '{ROW_PRESS, BTN_UP,   PIN_PRESSED,  64'hFFFF_FFFF_FFFF_FFFF,
      REG_DEBOUNCE, 20'd0, 1'b1, 4'd9},
    '{ROW_PRESS, BTN_UP,   PIN_PRESSED,  64'd99998,   REG_DEBOUNCE, 20'd0, 1'b0, 4'd0},
    '{ROW_PRESS, BTN_UP,   PIN_PRESSED,  64'd99999,   REG_DEBOUNCE, 20'd0, 1'b1, 4'd0},
    '{ROW_WRITE, BTN_UP,   PIN_PRESSED,  64'd0,       REG_RED,      20'd0, 1'b0, 4'd0},
    '{ROW_WRITE, BTN_UP,   PIN_PRESSED,  64'd0,       REG_DEBOUNCE, 20'd0, 1'b0, 4'd0},
    '{ROW_PRESS, BTN_UP,   PIN_PRESSED,  64'd99999,   REG_DEBOUNCE, 20'd0, 1'b1, 4'd1}
  };

  logic clk_i;
  logic rst_ni;

  ddmd_req_if req_if ();
  ddmd_pix_if pix_if ();
  ddmd_cfg_if cfg_if ();

  debounced_digit_matrix_display uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .pix_o  (pix_if),
    .cfg_i  (cfg_if)
  );

  // display state as the block should hold it
  logic [TIME_W-1:0]     last_up_us   = '0;
  logic [TIME_W-1:0]     last_down_us = '0;
  logic [DIGIT_W-1:0]    shown_digit  = BLANK_CODE;
  logic [DEBOUNCE_W-1:0] debounce_us  = DEBOUNCE_RST;
  logic [LEVEL_W-1:0]    red_lvl      = RED_RST;
  logic [LEVEL_W-1:0]    green_lvl    = GREEN_RST;
  logic [LEVEL_W-1:0]    blue_lvl     = BLUE_RST;

  pixel_t            expected_pixels [$];
  pixel_t            want;
  logic [TIME_W-1:0] timeline_us = '0;
  int unsigned       burst_left  = 1;
  int unsigned       errors      = 0;
  int unsigned       n_requests  = 0;
  int unsigned       n_frames    = 0;
  int unsigned       n_pixels    = 0;
  int unsigned       n_writes    = 0;
  int unsigned       idle_cycles = 0;
  logic [7:0]        ready_pat   = 8'hFF;
  logic [5:0]        ready_tick  = '0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic bit take_press(input logic sel, input logic lvl,
                                    input logic [TIME_W-1:0] t);
    logic [TIME_W-1:0] since;
    since = t - ((sel == BTN_DOWN) ? last_down_us : last_up_us);
    if (lvl != PIN_PRESSED || since < TIME_W'(debounce_us)) return 1'b0;
    if (sel == BTN_DOWN) begin
      last_down_us = t;
      shown_digit  = (shown_digit >= DIGITS) ? DIGIT_W'(DIGITS - 2)
                                             : DIGIT_W'((shown_digit + DIGITS - 1) % DIGITS);
    end else begin
      last_up_us  = t;
      shown_digit = (shown_digit >= DIGITS) ? DIGIT_W'(0)
                                            : DIGIT_W'((shown_digit + 1) % DIGITS);
    end
    return 1'b1;
  endfunction

  function automatic void queue_frame(input logic [DIGIT_W-1:0] digit);
    pixel_t px;
    logic   lit;
    for (int r = 0; r < SIDE; r++) begin
      for (int c = 0; c < SIDE; c++) begin
        lit = 1'b0;
        if (digit < DIGITS) lit = GLYPH[digit][r][SIDE-1-c];
        px.word  = {green_lvl, lit ? red_lvl : 8'h00, blue_lvl, 8'h00};
        px.index = PIX_INDEX_W'(r * SIDE + c);
        px.last  = (r * SIDE + c == FRAME_PIXELS - 1);
        expected_pixels.push_back(px);
      end
    end
    n_frames++;
  endfunction

  task automatic send_request(input logic sel, input logic lvl, input logic [TIME_W-1:0] t);
    req_if.valid         <= 1'b1;
    req_if.button_select <= sel;
    req_if.button_level  <= lvl;
    req_if.time_us       <= t;
    do @(posedge clk_i); while (!req_if.ready);
    n_requests++;
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      REG_DEBOUNCE: debounce_us = value;
      REG_RED:      red_lvl     = value[LEVEL_W-1:0];
      REG_GREEN:    green_lvl   = value[LEVEL_W-1:0];
      REG_BLUE:     blue_lvl    = value[LEVEL_W-1:0];
      default: ;
    endcase
    n_writes++;
  endtask

  task automatic wait_idle();
    req_if.valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (IDLE_TAIL) @(posedge clk_i);
  endtask

  task automatic pace_sender();
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 80 : $urandom_range(1, 10);
    end
  endtask

  // mostly timed presses around the debounce window, some noise and wrap-around
  task automatic pick_request(output logic sel, output logic lvl, output logic [TIME_W-1:0] t);
    int unsigned       roll;
    logic [TIME_W-1:0] iv;
    logic [TIME_W-1:0] base;
    roll = $urandom_range(0, 99);
    iv   = TIME_W'(debounce_us);
    sel  = 1'($urandom);
    lvl  = PIN_PRESSED;
    base = (sel == BTN_DOWN) ? last_down_us : last_up_us;
    if (roll < 8) begin
      lvl = PIN_RELEASED;
      t   = {$urandom, $urandom};
    end else if (roll < 14) begin
      t = {$urandom, $urandom};
    end else if (roll < 17) begin
      t           = 64'hFFFF_FFFF_FFFF_FFFF - TIME_W'($urandom_range(0, debounce_us));
      timeline_us = t;
    end else if (roll < 32) begin
      t = base + TIME_W'($urandom_range(0, debounce_us));
    end else if (roll < 47) begin
      t = base + iv - 1 + TIME_W'($urandom_range(0, 2));
    end else begin
      t           = timeline_us + iv + TIME_W'($urandom_range(0, 3 * debounce_us + 10));
      timeline_us = t;
    end
  endtask

  always @(posedge clk_i) begin
    if (ready_tick == '0) begin
      ready_pat <= ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
    end
    ready_tick   <= ready_tick + 1'b1;
    pix_if.ready <= ready_pat[ready_tick[2:0]];
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pix_if.valid && pix_if.ready) begin
        n_pixels++;
        if (expected_pixels.size() == 0) begin
          errors++;
          $display("%0t: unexpected pixel: expected none, actual word %h index %0d last %0b",
                   $time, pix_if.pixel_word, pix_if.pixel_index, pix_if.last_pixel);
        end else begin
          want = expected_pixels.pop_front();
          if (pix_if.pixel_word !== want.word) begin
            errors++;
            $display("%0t: pixel_word expected %h actual %h", $time, want.word,
                     pix_if.pixel_word);
          end
          if (pix_if.pixel_index !== want.index) begin
            errors++;
            $display("%0t: pixel_index expected %0d actual %0d", $time, want.index,
                     pix_if.pixel_index);
          end
          if (pix_if.last_pixel !== want.last) begin
            errors++;
            $display("%0t: last_pixel expected %0b actual %0b", $time, want.last,
                     pix_if.last_pixel);
          end
        end
      end
      if ((req_if.valid && req_if.ready) || (pix_if.valid && pix_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d pixels still pending", $time,
                 idle_cycles, expected_pixels.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    logic                  sel;
    logic                  lvl;
    logic [TIME_W-1:0]     t;
    logic [DEBOUNCE_W-1:0] iv_set;
    logic [LEVEL_W-1:0]    red_set;
    logic [LEVEL_W-1:0]    green_set;
    logic [LEVEL_W-1:0]    blue_set;

    rst_ni               = 1'b0;
    req_if.valid         = 1'b0;
    req_if.button_select = BTN_UP;
    req_if.button_level  = PIN_RELEASED;
    req_if.time_us       = '0;
    cfg_if.valid         = 1'b0;
    cfg_if.index         = REG_DEBOUNCE;
    cfg_if.data          = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_WRITE) begin
        if (i == 0 || DIRECTED[i-1].kind != ROW_WRITE) wait_idle();
        write_reg(DIRECTED[i].reg_idx, DIRECTED[i].data);
      end else begin
        cfg_if.valid <= 1'b0;
        send_request(DIRECTED[i].sel, DIRECTED[i].lvl, DIRECTED[i].t);
        void'(take_press(DIRECTED[i].sel, DIRECTED[i].lvl, DIRECTED[i].t));
        if (DIRECTED[i].frame) queue_frame(DIRECTED[i].digit);
        pace_sender();
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      case (ph)
        0: begin
          iv_set = 20'd1000000; red_set = 8'hFF; green_set = 8'hFF; blue_set = 8'hFF;
        end
        1: begin
          iv_set = 20'hFFFFF; red_set = 8'h01; green_set = 8'h00; blue_set = 8'h80;
        end
        2: begin
          iv_set = '0; red_set = 8'h80; green_set = 8'h7F; blue_set = 8'h01;
        end
        default: begin
          iv_set    = ph[0] ? DEBOUNCE_W'($urandom_range(1, 300))
                            : DEBOUNCE_W'($urandom_range(0, 1000000));
          red_set   = 8'($urandom);
          green_set = 8'($urandom);
          blue_set  = 8'($urandom);
        end
      endcase
      write_reg(REG_DEBOUNCE, iv_set);
      write_reg(REG_RED,   {12'($urandom), red_set});
      write_reg(REG_GREEN, {12'($urandom), green_set});
      write_reg(REG_BLUE,  {12'($urandom), blue_set});
      cfg_if.valid <= 1'b0;
      for (int n = 0; n < REQUESTS_PER_PHASE; n++) begin
        pick_request(sel, lvl, t);
        send_request(sel, lvl, t);
        if (take_press(sel, lvl, t)) begin
          queue_frame(shown_digit);
        end
        pace_sender();
      end
    end

    wait_idle();
    $display("Covered %0d button requests, %0d accepted presses, %0d pixels checked.",
             n_requests, n_frames, n_pixels);
    $display("%0d register writes over %0d settings, zero and full-scale among them.",
             n_writes, PHASES + 1);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
